// File: sv/icp_pkg.sv
// Package for the isometric cell picker: sizes, register codes and the token
// that moves along the column chain.
// No dependencies.
package icp_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_LEVELS = 16;

	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int LVL_W = 4;
	localparam int CNT_W = 7;
	localparam int DIM_W = 8;
	localparam int CRD_W = 16;
	localparam int ACC_W = 30;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_HALF_WIDTH   = 3'd0,
		REG_HALF_HEIGHT  = 3'd1,
		REG_ROW_COUNT    = 3'd2,
		REG_COL_COUNT    = 3'd3,
		REG_ACTIVE_LEVEL = 3'd4
	} cfg_reg_t;

	// one grid row travelling through the column cells
	typedef struct packed {
		logic                    vld;
		logic                    last;
		logic                    row_ok;
		logic [ROW_W-1:0]        row;
		logic signed [ACC_W-1:0] s;
		logic                    hit;
		logic [COL_W-1:0]        col;
	} tok_t;

endpackage

// File: sv/icp_cell.sv
// One column cell of the picker chain: tests its column against the row token
// and hands the token, with the next column's sum, to its neighbor.
// Depends on icp_pkg.
module icp_cell
	import icp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  tok_t                    tin,
	input  logic [COL_W-1:0]        idx,
	input  logic [CNT_W-1:0]        cols,
	input  logic signed [ACC_W-1:0] two_p,
	output tok_t                    tout
);

	tok_t tok_q;
	tok_t tok_d;
	logic col_ok;
	logic hit;

	assign col_ok = (CNT_W'(idx) < cols) && (tin.s >= 0) && (tin.s <= two_p);
	assign hit    = tin.row_ok && col_ok;

	always_comb begin
		tok_d     = tin;
		tok_d.s   = tin.s - two_p;
		tok_d.hit = tin.hit | hit;
		tok_d.col = hit ? idx : tin.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tout = tok_q;

endmodule

// File: sv/icp_front.sv
// Front end of the picker: forms the per-item sums in three stages, then
// issues one row token per cycle into the column chain.
// Depends on icp_pkg.
module icp_front
	import icp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [CRD_W-1:0] point_x,
	input  logic signed [CRD_W-1:0] point_y,
	input  logic signed [CRD_W-1:0] camera_x,
	input  logic signed [CRD_W-1:0] camera_y,
	input  logic [DIM_W-1:0]        half_width,
	input  logic [DIM_W-1:0]        half_height,
	input  logic [LVL_W-1:0]        level,
	input  logic [CNT_W-1:0]        rows,
	output tok_t                    tok,
	output logic signed [ACC_W-1:0] two_p
);

	logic                      v_s1, v_s2, scan_q;
	logic signed [CRD_W+1:0]   dx_s1;
	logic signed [CRD_W:0]     dy_s1;
	logic [2*DIM_W-1:0]        p_s1;
	logic signed [ACC_W-1:0]   a_s2, b_s2, pk_s2, two_p_q;
	logic signed [ACC_W-1:0]   s0_q, d_q;
	logic [CNT_W-1:0]          i_q;
	logic [CNT_W-1:0]          last_row;
	logic                      lvl_ok;
	logic                      row_ok;

	assign last_row = (rows == '0) ? '0 : rows - CNT_W'(1);
	assign lvl_ok   = 32'(level) < MAX_LEVELS;
	assign row_ok   = (i_q < rows) && lvl_ok && (d_q >= 0) && (d_q <= two_p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			scan_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			if (v_s2) begin
				scan_q <= 1'b1;
			end else if (scan_q && i_q == last_row) begin
				scan_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= (CRD_W+2)'(point_x) - (CRD_W+2)'(camera_x)
			- (CRD_W+2)'(half_width);
		dy_s1   <= (CRD_W+1)'(point_y) - (CRD_W+1)'(camera_y);
		p_s1    <= (2*DIM_W)'(half_width) * (2*DIM_W)'(half_height);
		a_s2    <= ACC_W'(dx_s1) * ACC_W'(half_height);
		b_s2    <= ACC_W'(dy_s1) * ACC_W'(half_width);
		pk_s2   <= ACC_W'(p_s1) * ACC_W'(level);
		two_p_q <= ACC_W'({p_s1, 1'b0});
		if (v_s2) begin
			s0_q <= b_s2 + pk_s2 + a_s2;
			d_q  <= b_s2 + pk_s2 - a_s2;
			i_q  <= '0;
		end else if (scan_q) begin
			d_q <= d_q - two_p_q;
			i_q <= i_q + CNT_W'(1);
		end
	end

	always_comb begin
		tok        = '0;
		tok.vld    = scan_q;
		tok.last   = i_q == last_row;
		tok.row_ok = row_ok;
		tok.row    = i_q[ROW_W-1:0];
		tok.s      = s0_q;
	end

	assign two_p = two_p_q;

endmodule

// File: sv/isometric_cell_picker_unit.sv
// Isometric cell picker: finds the diamond cell of the active level that holds
// a screen point. Chain of column cells fed by icp_front, depends on icp_pkg.
//
// Input item (s_t*): query point and camera offset. Config (cfg_*): register
// index and data, always ready; the user must write it only while the unit
// is idle, the unit does not enforce this. Result item (m_t*): hit flag and
// held selection, one per input item. A row token enters the chain each
// cycle, one column cell per stage, so the result is registered after the
// last row token leaves the column chain, and the next item is taken only
// once that result is emitted; the row scan and the chain length set this.
// One item is worked at a time; the next may be taken while the previous
// result still waits in the output register. A stalled receiver holds the
// result and, once the next scan is done, holds the unit in its final state.
// Reset: half_width 64, half_height 32, counts and level 0, selection 0,
// no result pending.
module isometric_cell_picker_unit
	import icp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // point_x, point_y, camera_x, camera_y
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // hit, sel_row, sel_col, sel_level, zeros
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BUSY = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  state_q;
	logic [DIM_W-1:0]        hw_q, hh_q;
	logic [CNT_W-1:0]        row_cnt_q, col_cnt_q;
	logic [LVL_W-1:0]        level_q;
	logic [CNT_W-1:0]        rows, cols;
	logic [ROW_W-1:0]        held_row_q, best_row_q;
	logic [COL_W-1:0]        held_col_q, best_col_q;
	logic [LVL_W-1:0]        held_lvl_q;
	logic                    found_q;
	logic                    out_vld_q;
	logic [23:0]             out_q;
	logic                    start;
	logic                    emit;
	logic signed [ACC_W-1:0] two_p;
	tok_t                    chain [MAX_COLS+1];

	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == ST_IDLE;
	assign start     = s_tvalid && s_tready;
	assign emit      = (state_q == ST_DONE) && (!out_vld_q || m_tready);

	assign rows = (row_cnt_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_cnt_q;
	assign cols = (col_cnt_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q      <= DIM_W'(64);
			hh_q      <= DIM_W'(32);
			row_cnt_q <= '0;
			col_cnt_q <= '0;
			level_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_WIDTH:   hw_q      <= cfg_data;
				REG_HALF_HEIGHT:  hh_q      <= cfg_data;
				REG_ROW_COUNT:    row_cnt_q <= cfg_data[CNT_W-1:0];
				REG_COL_COUNT:    col_cnt_q <= cfg_data[CNT_W-1:0];
				REG_ACTIVE_LEVEL: level_q   <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	icp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.point_x     (s_tdata[15:0]),
		.point_y     (s_tdata[31:16]),
		.camera_x    (s_tdata[47:32]),
		.camera_y    (s_tdata[63:48]),
		.half_width  (hw_q),
		.half_height (hh_q),
		.level       (level_q),
		.rows        (rows),
		.tok         (chain[0]),
		.two_p       (two_p)
	);

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
		icp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[j]),
			.idx    (COL_W'(j)),
			.cols   (cols),
			.two_p  (two_p),
			.tout   (chain[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			found_q    <= 1'b0;
			best_row_q <= '0;
			best_col_q <= '0;
			held_row_q <= '0;
			held_col_q <= '0;
			held_lvl_q <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (chain[MAX_COLS].vld) begin
						if (chain[MAX_COLS].hit) begin
							found_q    <= 1'b1;
							best_row_q <= chain[MAX_COLS].row;
							best_col_q <= chain[MAX_COLS].col;
						end
						if (chain[MAX_COLS].last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (emit) begin
						if (found_q) begin
							held_row_q <= best_row_q;
							held_col_q <= best_col_q;
							held_lvl_q <= level_q;
							out_q <= {7'd0, level_q, best_col_q, best_row_q, 1'b1};
						end else begin
							out_q <= {7'd0, held_lvl_q, held_col_q, held_row_q, 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule
